// File: hw/rtl/pso_pkg.sv
// Package for the particle swarm update block: widths, record layout, register indexes.
package pso_pkg;
    localparam int NumParticles = 16;
    localparam int IdxW = 4;
    localparam int ScoreW = 34;

    typedef enum logic [3:0] {
        REG_BOUND_LOW  = 4'd0,
        REG_BOUND_HIGH = 4'd1,
        REG_TARGET_X   = 4'd2,
        REG_TARGET_Y   = 4'd3,
        REG_TARGET_Z   = 4'd4,
        REG_INERTIA    = 4'd5,
        REG_COGNITIVE  = 4'd6,
        REG_SOCIAL     = 4'd7
    } t_reg_idx;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    // one particle record as held in the store
    typedef struct packed {
        logic [ScoreW-1:0] pbv;
        logic [47:0] pbp;
        logic [47:0] vel;
        logic [47:0] pos;
    } t_rec;

    localparam int RecW = $bits(t_rec);
endpackage

// File: hw/rtl/pso_store.sv
// Particle record memory: one write port, one registered read port.
module pso_store import pso_pkg::*; (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [IdxW-1:0]     i_waddr,
    input  t_rec                i_wdata,
    input  logic [IdxW-1:0]     i_raddr,
    output t_rec                o_rdata
);
    t_rec r_mem [NumParticles];
    t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/pso_vel.sv
// Velocity, move and clamp for one dimension, two register stages.
module pso_vel import pso_pkg::*; (
    input  logic               i_clk,
    input  logic signed [15:0] i_v,
    input  logic signed [15:0] i_p,
    input  logic signed [15:0] i_pb,
    input  logic signed [15:0] i_gb,
    input  logic signed [15:0] i_r1,
    input  logic signed [15:0] i_r2,
    input  logic        [11:0] i_w,
    input  logic        [11:0] i_c1,
    input  logic        [11:0] i_c2,
    input  logic signed [15:0] i_lo,
    input  logic signed [15:0] i_hi,
    output logic signed [15:0] o_v,
    output logic signed [15:0] o_p
);
    logic signed [28:0] r_t0;
    logic signed [28:0] r_t1;
    logic signed [28:0] r_t2;
    logic signed [15:0] r_p;
    logic signed [15:0] r_r1;
    logic signed [15:0] r_r2;
    logic signed [44:0] r_s1;
    logic signed [44:0] r_s2;
    logic signed [44:0] r_s0;
    logic signed [15:0] r_p2;
    logic signed [16:0] d1;
    logic signed [16:0] d2;
    logic signed [28:0] m0;
    logic signed [28:0] m1;
    logic signed [28:0] m2;
    logic signed [44:0] m3;
    logic signed [44:0] m4;
    logic signed [46:0] sum;
    logic signed [46:0] q;
    logic signed [15:0] vs;
    logic signed [16:0] np;

    assign d1 = 17'(i_pb) - 17'(i_p);
    assign d2 = 17'(i_gb) - 17'(i_p);

    assign m0 = 29'($signed({1'b0, i_w})) * 29'(i_v);
    assign m1 = 29'($signed({1'b0, i_c1})) * 29'(d1);
    assign m2 = 29'($signed({1'b0, i_c2})) * 29'(d2);
    assign m3 = 45'(r_t1) * 45'(r_r1);
    assign m4 = 45'(r_t2) * 45'(r_r2);

    // stage 1: c*d products and w*v; stage 2: r1/r2 products and shifted w*v
    always_ff @(posedge i_clk) begin
        r_t0 <= m0;
        r_t1 <= m1;
        r_t2 <= m2;
        r_p  <= i_p;
        r_s0 <= 45'(r_t0) <<< 15;
        r_s1 <= m3;
        r_s2 <= m4;
        r_p2 <= r_p;
    end

    always_ff @(posedge i_clk) begin
        r_r1 <= i_r1;
        r_r2 <= i_r2;
    end

    // round to nearest, ties up, then saturate
    assign sum = 47'(r_s0) + 47'(r_s1) + 47'(r_s2) + 47'(1 << 22);
    assign q = sum >>> 23;
    assign vs = (q > 47'sd32767) ? 16'sd32767 :
                (q < -47'sd32768) ? -16'sd32768 : q[15:0];
    assign np = 17'(r_p2) + 17'(vs);

    always_comb begin
        logic signed [16:0] c;
        c = np;
        if (c < 17'(i_lo)) c = 17'(i_lo);
        if (c > 17'(i_hi)) c = 17'(i_hi);
        o_p = c[15:0];
        o_v = vs;
    end
endmodule

// File: hw/rtl/pso_particle_update.sv
// Top level of the particle swarm update block.
// One request at a time: a load passes from acceptance to a result in the
// output register through memory read, score and write back; an update passes
// through memory read, score, best update, two velocity multiply stages, write
// back. The registered record memory read and the swarm best dependency set
// these steps. The result waits in an output register, and the next request is
// taken at the earliest in the cycle after the result is accepted.
module pso_particle_update import pso_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // particle, a_x, a_y, a_z, b_x, b_y, b_z (pad)
    input  logic         s_axis_tuser,  // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [207:0] m_axis_tdata,  // particle_out, score, personal_best_score,
                                        // swarm_best_score, global_best_x/y/z,
                                        // new_x/y/z (pad)
    input  logic         i_cfg_we,
    input  logic [3:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data
);
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001, ST_READ = 6'b000010, ST_SCORE = 6'b000100,
        ST_BEST = 6'b001000, ST_VEL = 6'b010000, ST_DONE = 6'b100000
    } t_state;

    t_state r_state;
    logic [1:0] r_cnt;
    logic signed [15:0] r_lo, r_hi, r_tx, r_ty, r_tz;
    logic [11:0] r_w, r_c1, r_c2;
    logic [47:0] r_gbp;
    logic [ScoreW-1:0] r_gbv;
    logic r_func;
    logic [IdxW-1:0] r_idx;
    logic [95:0] r_ab;
    t_rec r_rec;
    logic [ScoreW-1:0] r_score;
    logic r_ovalid;
    logic [207:0] r_odata;

    t_rec rd, wdata;
    logic we;
    logic signed [15:0] ax [3], bx [3], pp [3], tt [3];
    logic signed [15:0] vo [3], po [3];
    logic [ScoreW-1:0] sc;

    assign s_axis_tready = (r_state == ST_IDLE) && !r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= 16'sd0; r_hi <= 16'sd25600;
            r_tx <= 16'sd12800; r_ty <= 16'sd12800; r_tz <= 16'sd12800;
            r_w <= 12'd128; r_c1 <= 12'd384; r_c2 <= 12'd384;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BOUND_LOW:  r_lo <= i_cfg_data;
                REG_BOUND_HIGH: r_hi <= i_cfg_data;
                REG_TARGET_X:   r_tx <= i_cfg_data;
                REG_TARGET_Y:   r_ty <= i_cfg_data;
                REG_TARGET_Z:   r_tz <= i_cfg_data;
                REG_INERTIA:    r_w  <= i_cfg_data[11:0];
                REG_COGNITIVE:  r_c1 <= i_cfg_data[11:0];
                REG_SOCIAL:     r_c2 <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    assign tt[0] = r_tx; assign tt[1] = r_ty; assign tt[2] = r_tz;
    // score the fresh memory read for an update, the request position for a load
    always_comb begin
        logic signed [16:0] d;
        logic signed [33:0] dsq;
        sc = '0;
        for (int j = 0; j < 3; j++) begin
            ax[j] = r_ab[16*j +: 16];
            bx[j] = r_ab[48+16*j +: 16];
            pp[j] = (r_func == FUNC_LOAD) ? ax[j] : rd.pos[16*j +: 16];
            d = 17'(pp[j]) - 17'(tt[j]);
            dsq = 34'(d) * 34'(d);
            sc = sc + ScoreW'($unsigned(dsq));
        end
    end

    pso_store u_store (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_idx), .i_wdata(wdata),
        .i_raddr(r_idx), .o_rdata(rd)
    );

    for (genvar g = 0; g < 3; g++) begin : g_dim
        pso_vel u_vel (
            .i_clk(i_clk), .i_v(r_rec.vel[16*g +: 16]), .i_p(r_rec.pos[16*g +: 16]),
            .i_pb(r_rec.pbp[16*g +: 16]), .i_gb(r_gbp[16*g +: 16]),
            .i_r1(ax[g]), .i_r2(bx[g]), .i_w(r_w), .i_c1(r_c1), .i_c2(r_c2),
            .i_lo(r_lo), .i_hi(r_hi), .o_v(vo[g]), .o_p(po[g])
        );
    end

    always_comb begin
        wdata = r_rec;
        we = 1'b0;
        if (r_state == ST_SCORE && r_func == FUNC_LOAD) begin
            wdata.pos = r_ab[47:0]; wdata.pbp = r_ab[47:0];
            wdata.vel = r_ab[95:48]; wdata.pbv = sc;
            we = 1'b1;
        end else if (r_state == ST_DONE) begin
            wdata.pos = {po[2], po[1], po[0]};
            wdata.vel = {vo[2], vo[1], vo[0]};
            we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_ovalid <= 1'b0;
            r_gbp <= '0; r_gbv <= '1; r_cnt <= '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_func <= s_axis_tuser; r_idx <= s_axis_tdata[3:0];
                    r_ab <= s_axis_tdata[99:4]; r_state <= ST_READ;
                end
                ST_READ: r_state <= ST_SCORE;
                ST_SCORE: begin
                    r_rec <= rd; r_score <= sc;
                    if (r_func == FUNC_LOAD) begin
                        r_odata <= {6'd0, r_ab[47:0], r_gbp, r_gbv, sc, sc, r_idx};
                        r_ovalid <= 1'b1; r_state <= ST_IDLE;
                    end else r_state <= ST_BEST;
                end
                ST_BEST: begin
                    if (r_score < r_rec.pbv) begin
                        r_rec.pbv <= r_score; r_rec.pbp <= r_rec.pos;
                    end
                    if (r_score < r_gbv) begin
                        r_gbv <= r_score; r_gbp <= r_rec.pos;
                    end
                    r_cnt <= '0; r_state <= ST_VEL;
                end
                ST_VEL: begin
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd1) r_state <= ST_DONE;
                end
                ST_DONE: begin
                    r_odata <= {6'd0, po[2], po[1], po[0], r_gbp, r_gbv,
                                r_rec.pbv, r_score, r_idx};
                    r_ovalid <= 1'b1; r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;

    a_best_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gbv <= $past(r_gbv)) else $error("swarm best score grew");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    a_write_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_state == ST_SCORE || r_state == ST_DONE)) else $error("stray write");
endmodule
